// ===== design/rbsi_pkg.sv =====
// ============================================================================
// Ray/box slab intersection - shared package
// Widths, stage counts, register codes and the item side-band type used by
// the slab intersection pipeline.
// ============================================================================
package rbsi_pkg;

  // Number format: signed coordinates, FRAC_BITS fraction bits
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // Slab numerator (bound - origin) and the shifted dividend
  localparam int NUM_W      = COORD_WIDTH + 1;
  localparam int DVD_W      = NUM_W + FRAC_BITS;
  // Divider: quotient bits resolved per stage
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = (DVD_W + DIV_BITS - 1) / DIV_BITS;
  localparam int QW         = DIV_STAGES * DIV_BITS;
  // Ray parameter t, signed
  localparam int TW         = QW + 1;
  // Quotient magnitude limit
  localparam int QCAP_BIT   = 61;
  localparam logic [QW-1:0] QCAP = QW'(1) << QCAP_BIT;

  // Split of t for the position multiply
  localparam int TLO_W  = (QW + 1) / 2;
  localparam int THI_W  = QW - TLO_W;
  localparam int PROD_W = QW + COORD_WIDTH;

  // Square root: root bits per stage
  localparam int SQ_BITS   = 3;
  localparam int SQ_STAGES = (COORD_WIDTH + 1 + SQ_BITS - 1) / SQ_BITS;
  localparam int RW        = SQ_STAGES * SQ_BITS;
  localparam int SUM_W     = 2 * COORD_WIDTH + 2;
  localparam int REM_W     = RW + 3;

  // Sentinels for the running entry / exit parameters
  localparam logic signed [TW-1:0] T_NEG_SENT = {1'b1, {QW{1'b0}}};
  localparam logic signed [TW-1:0] T_POS_SENT = {1'b0, {QW{1'b1}}};

  // Saturation bounds for a hit coordinate, in the widened sum format
  localparam logic signed [COORD_WIDTH+1:0] V_MAX = {3'b000, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH+1:0] V_MIN = {3'b111, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Configuration register codes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } reg_index_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [COORD_WIDTH-1:0]        dist_t;

  // Ray data that travels alongside the divider
  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] o;
    logic [2:0][COORD_WIDTH-1:0] d;
    logic [COORD_WIDTH-1:0]      best;
    logic [2:0]                  neg_lo;
    logic [2:0]                  neg_hi;
    logic [2:0]                  dnz;
    logic                        par_ok;
  } ray_side_t;

endpackage

// ===== design/rbsi_ray_if.sv =====
// ============================================================================
// Ray/box slab intersection - ray channel
// Valid/ready channel carrying one ray item.
// ============================================================================
interface rbsi_ray_if import rbsi_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t ray_origin_x;
  coord_t ray_origin_y;
  coord_t ray_origin_z;
  coord_t ray_direction_x;
  coord_t ray_direction_y;
  coord_t ray_direction_z;
  dist_t  best_distance;

  modport source (
    output valid, ray_origin_x, ray_origin_y, ray_origin_z,
    output ray_direction_x, ray_direction_y, ray_direction_z, best_distance,
    input  ready
  );
  modport sink (
    input  valid, ray_origin_x, ray_origin_y, ray_origin_z,
    input  ray_direction_x, ray_direction_y, ray_direction_z, best_distance,
    output ready
  );
endinterface

// ===== design/rbsi_res_if.sv =====
// ============================================================================
// Ray/box slab intersection - result channel
// Valid/ready channel carrying one hit result item.
// ============================================================================
interface rbsi_res_if import rbsi_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   hit;
  dist_t  hit_distance;
  coord_t hit_x;
  coord_t hit_y;
  coord_t hit_z;

  modport source (
    output valid, hit, hit_distance, hit_x, hit_y, hit_z,
    input  ready
  );
  modport sink (
    input  valid, hit, hit_distance, hit_x, hit_y, hit_z,
    output ready
  );
endinterface

// ===== design/ray_box_slab_intersect_unit.sv =====
// ============================================================================
// Ray/box slab intersection unit
// Fixed-point ray versus axis-aligned box test (slab method) with hit
// position and Euclidean hit distance, fully pipelined.
// ============================================================================
// Usage:
//   Write the box corners through cfg_we/cfg_index/cfg_data while no ray is in
//   flight (index 0..2 lower corner x/y/z, 3..5 upper corner x/y/z).
//   Rays enter on the ray channel (origin, direction, best distance so far);
//   one result item leaves on the res channel for every ray, in order.
//   The pipeline has one input register, DIV_STAGES (13) divider stages
//   for the six slab parameters, six stages for the slab reduction, position
//   multiply and squaring, SQ_STAGES (11) square-root stages and the output
//   register. Throughput is one ray per cycle unless stalled; the divider
//   and square-root pipelines resolve DIV_BITS and SQ_BITS bits per stage.
//   Every stage moves on a single advance signal, taken when the output
//   register is empty or being read. When the receiver stalls with a result
//   waiting, the whole pipeline holds and ray.ready drops; nothing is lost.
//   Reset (rst, synchronous) clears all stage valid bits and the box to zero.
// ============================================================================
module ray_box_slab_intersect_unit import rbsi_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data,
  rbsi_ray_if.sink               ray,
  rbsi_res_if.source             res
);

  // --------------------------------------------------------------------------
  // Box registers
  // --------------------------------------------------------------------------
  coord_t box_lo [3];
  coord_t box_hi [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_lo[a] <= '0;
        box_hi[a] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_MIN_X: box_lo[0] <= cfg_data;
        REG_BOX_MIN_Y: box_lo[1] <= cfg_data;
        REG_BOX_MIN_Z: box_lo[2] <= cfg_data;
        REG_BOX_MAX_X: box_hi[0] <= cfg_data;
        REG_BOX_MAX_Y: box_hi[1] <= cfg_data;
        REG_BOX_MAX_Z: box_hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Global advance
  // --------------------------------------------------------------------------
  logic adv;
  logic out_valid;

  assign adv       = !out_valid || res.ready;
  assign ray.ready = adv;

  // --------------------------------------------------------------------------
  // Stage 0: numerators, magnitudes, parallel-slab check
  // --------------------------------------------------------------------------
  coord_t ray_o [3];
  coord_t ray_d [3];

  assign ray_o[0] = ray.ray_origin_x;
  assign ray_o[1] = ray.ray_origin_y;
  assign ray_o[2] = ray.ray_origin_z;
  assign ray_d[0] = ray.ray_direction_x;
  assign ray_d[1] = ray.ray_direction_y;
  assign ray_d[2] = ray.ray_direction_z;

  ray_side_t              s0_side_next;
  logic [NUM_W-1:0]       nlo_next [3];
  logic [NUM_W-1:0]       nhi_next [3];
  logic [COORD_WIDTH-1:0] den_next [3];

  always_comb begin
    logic signed [NUM_W-1:0] nl;
    logic signed [NUM_W-1:0] nh;
    s0_side_next.best   = ray.best_distance;
    s0_side_next.par_ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      nl = NUM_W'(box_lo[a]) - NUM_W'(ray_o[a]);
      nh = NUM_W'(box_hi[a]) - NUM_W'(ray_o[a]);
      nlo_next[a] = nl[NUM_W-1] ? NUM_W'(-nl) : NUM_W'(nl);
      nhi_next[a] = nh[NUM_W-1] ? NUM_W'(-nh) : NUM_W'(nh);
      den_next[a] = ray_d[a][COORD_WIDTH-1] ? COORD_WIDTH'(-ray_d[a])
                                            : COORD_WIDTH'(ray_d[a]);
      s0_side_next.o[a]      = ray_o[a];
      s0_side_next.d[a]      = ray_d[a];
      s0_side_next.neg_lo[a] = nl[NUM_W-1] ^ ray_d[a][COORD_WIDTH-1];
      s0_side_next.neg_hi[a] = nh[NUM_W-1] ^ ray_d[a][COORD_WIDTH-1];
      s0_side_next.dnz[a]    = (ray_d[a] != '0);
      // parallel slab: origin must lie between the bounds
      if (ray_d[a] == '0 && (ray_o[a] < box_lo[a] || ray_o[a] > box_hi[a]))
        s0_side_next.par_ok = 1'b0;
    end
  end

  logic                   s0_valid;
  ray_side_t              s0_side;
  logic [NUM_W-1:0]       s0_nlo [3];
  logic [NUM_W-1:0]       s0_nhi [3];
  logic [COORD_WIDTH-1:0] s0_den [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= ray.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side <= s0_side_next;
      for (int a = 0; a < 3; a++) begin
        s0_nlo[a] <= nlo_next[a];
        s0_nhi[a] <= nhi_next[a];
        s0_den[a] <= den_next[a];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Slab dividers (six in parallel) and the matching side line
  // --------------------------------------------------------------------------
  logic [QW-1:0] q_lo [3];
  logic [QW-1:0] q_hi [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbsi_div_pipe u_div_lo (
      .clk     (clk),
      .en      (adv),
      .num_mag (s0_nlo[a]),
      .den_mag (s0_den[a]),
      .quot    (q_lo[a])
    );
    rbsi_div_pipe u_div_hi (
      .clk     (clk),
      .en      (adv),
      .num_mag (s0_nhi[a]),
      .den_mag (s0_den[a]),
      .quot    (q_hi[a])
    );
  end

  logic      dv_valid [0:DIV_STAGES];
  ray_side_t dv_side  [0:DIV_STAGES];

  assign dv_valid[0] = s0_valid;
  assign dv_side[0]  = s0_side;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div_side
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[s+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[s+1] <= dv_valid[s];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) dv_side[s+1] <= dv_side[s];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: signed slab parameters, near/far per axis
  // --------------------------------------------------------------------------
  logic signed [TW-1:0] tn_next [3];
  logic signed [TW-1:0] tf_next [3];

  always_comb begin
    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t2;
    for (int a = 0; a < 3; a++) begin
      t1 = $signed({1'b0, q_lo[a]});
      t2 = $signed({1'b0, q_hi[a]});
      if (dv_side[DIV_STAGES].neg_lo[a]) t1 = -t1;
      if (dv_side[DIV_STAGES].neg_hi[a]) t2 = -t2;
      tn_next[a] = (t1 < t2) ? t1 : t2;
      tf_next[a] = (t1 < t2) ? t2 : t1;
    end
  end

  logic                 s1_valid;
  ray_side_t            s1_side;
  logic signed [TW-1:0] s1_tn [3];
  logic signed [TW-1:0] s1_tf [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= dv_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side <= dv_side[DIV_STAGES];
      for (int a = 0; a < 3; a++) begin
        s1_tn[a] <= tn_next[a];
        s1_tf[a] <= tf_next[a];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: entry/exit reduction, hit decision, chosen parameter
  // --------------------------------------------------------------------------
  logic          ok2_next;
  logic [QW-1:0] tval_next;

  always_comb begin
    logic signed [TW-1:0] tmin;
    logic signed [TW-1:0] tmax;
    tmin = T_NEG_SENT;
    tmax = T_POS_SENT;
    for (int a = 0; a < 3; a++) begin
      if (s1_side.dnz[a]) begin
        if (s1_tn[a] > tmin) tmin = s1_tn[a];
        if (s1_tf[a] < tmax) tmax = s1_tf[a];
      end
    end
    ok2_next  = s1_side.par_ok && (s1_side.dnz != '0) && (tmin <= tmax) && !tmax[TW-1];
    // origin inside the box: use the exit parameter
    tval_next = tmin[TW-1] ? tmax[QW-1:0] : tmin[QW-1:0];
  end

  logic          s2_valid;
  logic          s2_ok;
  ray_side_t     s2_side;
  logic [QW-1:0] s2_tval;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ok   <= ok2_next;
      s2_side <= s1_side;
      s2_tval <= tval_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: partial products t * |d|
  // --------------------------------------------------------------------------
  logic                          s3_valid;
  logic                          s3_ok;
  ray_side_t                     s3_side;
  logic [TLO_W+COORD_WIDTH-1:0]  s3_pl [3];
  logic [THI_W+COORD_WIDTH-1:0]  s3_ph [3];
  logic [COORD_WIDTH-1:0]        dmag  [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dmag[a] = s2_side.d[a][COORD_WIDTH-1] ? COORD_WIDTH'(-$signed(s2_side.d[a]))
                                            : s2_side.d[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ok   <= s2_ok;
      s3_side <= s2_side;
      for (int a = 0; a < 3; a++) begin
        s3_pl[a] <= s2_tval[TLO_W-1:0] * dmag[a];
        s3_ph[a] <= s2_tval[QW-1:TLO_W] * dmag[a];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: hit position, saturated to the coordinate range
  // --------------------------------------------------------------------------
  logic [COORD_WIDTH-1:0] p_next [3];

  always_comb begin
    logic [PROD_W-1:0]          prod;
    logic [PROD_W-FRAC_BITS-1:0] m;
    logic signed [COORD_WIDTH+1:0] vs;
    logic                       dneg;
    for (int a = 0; a < 3; a++) begin
      prod = (PROD_W'(s3_ph[a]) << TLO_W) + PROD_W'(s3_pl[a]);
      m    = prod[PROD_W-1:FRAC_BITS];
      dneg = s3_side.d[a][COORD_WIDTH-1];
      if (dneg)
        vs = (COORD_WIDTH+2)'($signed(s3_side.o[a]))
           - $signed({2'b00, m[COORD_WIDTH-1:0]});
      else
        vs = (COORD_WIDTH+2)'($signed(s3_side.o[a]))
           + $signed({2'b00, m[COORD_WIDTH-1:0]});
      if (m[PROD_W-FRAC_BITS-1:COORD_WIDTH] != '0)
        p_next[a] = dneg ? C_MIN : C_MAX;
      else if (vs > V_MAX)
        p_next[a] = C_MAX;
      else if (vs < V_MIN)
        p_next[a] = C_MIN;
      else
        p_next[a] = vs[COORD_WIDTH-1:0];
    end
  end

  logic                        s4_valid;
  logic                        s4_ok;
  logic [2:0][COORD_WIDTH-1:0] s4_p;
  logic [2:0][COORD_WIDTH-1:0] s4_o;
  logic [COORD_WIDTH-1:0]      s4_best;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ok   <= s3_ok;
      s4_o    <= s3_side.o;
      s4_best <= s3_side.best;
      for (int a = 0; a < 3; a++) s4_p[a] <= p_next[a];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: squared deltas
  // --------------------------------------------------------------------------
  logic [COORD_WIDTH-1:0] dm [3];

  always_comb begin
    logic signed [COORD_WIDTH:0] df;
    for (int a = 0; a < 3; a++) begin
      df    = (COORD_WIDTH+1)'($signed(s4_p[a])) - (COORD_WIDTH+1)'($signed(s4_o[a]));
      dm[a] = df[COORD_WIDTH] ? COORD_WIDTH'(-df) : df[COORD_WIDTH-1:0];
    end
  end

  logic                        s5_valid;
  logic                        s5_ok;
  logic [2:0][COORD_WIDTH-1:0] s5_p;
  logic [COORD_WIDTH-1:0]      s5_best;
  logic [2*COORD_WIDTH-1:0]    s5_sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ok   <= s4_ok;
      s5_p    <= s4_p;
      s5_best <= s4_best;
      for (int a = 0; a < 3; a++) s5_sq[a] <= dm[a] * dm[a];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: sum of squares
  // --------------------------------------------------------------------------
  logic                        s6_valid;
  logic                        s6_ok;
  logic [2:0][COORD_WIDTH-1:0] s6_p;
  logic [COORD_WIDTH-1:0]      s6_best;
  logic [SUM_W-1:0]            s6_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (adv) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_ok   <= s5_ok;
      s6_p    <= s5_p;
      s6_best <= s5_best;
      s6_sum  <= SUM_W'(s5_sq[0]) + SUM_W'(s5_sq[1]) + SUM_W'(s5_sq[2]);
    end
  end

  // --------------------------------------------------------------------------
  // Square-root pipeline, SQ_BITS root bits per stage
  // --------------------------------------------------------------------------
  logic                        sq_valid [0:SQ_STAGES];
  logic                        sq_ok    [0:SQ_STAGES];
  logic [2:0][COORD_WIDTH-1:0] sq_p     [0:SQ_STAGES];
  logic [COORD_WIDTH-1:0]      sq_best  [0:SQ_STAGES];
  logic [2*RW-1:0]             sq_rad   [0:SQ_STAGES];
  logic [RW-1:0]               sq_root  [0:SQ_STAGES];
  logic [REM_W-1:0]            sq_rem   [0:SQ_STAGES];

  assign sq_valid[0] = s6_valid;
  assign sq_ok[0]    = s6_ok;
  assign sq_p[0]     = s6_p;
  assign sq_best[0]  = s6_best;
  assign sq_rad[0]   = (2*RW)'(s6_sum);
  assign sq_root[0]  = '0;
  assign sq_rem[0]   = '0;

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sqrt
    logic [2*RW-1:0]  rad_next;
    logic [RW-1:0]    root_next;
    logic [REM_W-1:0] rem_next;

    // one root bit per step from each pair of radicand bits
    always_comb begin
      logic [2*RW-1:0]  rd;
      logic [RW-1:0]    rt;
      logic [REM_W-1:0] rm;
      logic [REM_W-1:0] trial;
      rd = sq_rad[s];
      rt = sq_root[s];
      rm = sq_rem[s];
      for (int k = 0; k < SQ_BITS; k++) begin
        rm    = {rm[REM_W-3:0], rd[2*RW-1:2*RW-2]};
        rd    = {rd[2*RW-3:0], 2'b00};
        trial = REM_W'({rt, 2'b01});
        if (rm >= trial) begin
          rm = rm - trial;
          rt = {rt[RW-2:0], 1'b1};
        end else begin
          rt = {rt[RW-2:0], 1'b0};
        end
      end
      rad_next  = rd;
      root_next = rt;
      rem_next  = rm;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[s+1] <= 1'b0;
      end else if (adv) begin
        sq_valid[s+1] <= sq_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_ok[s+1]   <= sq_ok[s];
        sq_p[s+1]    <= sq_p[s];
        sq_best[s+1] <= sq_best[s];
        sq_rad[s+1]  <= rad_next;
        sq_root[s+1] <= root_next;
        sq_rem[s+1]  <= rem_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: saturate distance, compare with best
  // --------------------------------------------------------------------------
  dist_t dist_sat;
  logic  hit_next;

  assign dist_sat = (sq_root[SQ_STAGES][RW-1:COORD_WIDTH] != '0) ? '1
                  : sq_root[SQ_STAGES][COORD_WIDTH-1:0];
  assign hit_next = sq_ok[SQ_STAGES] && (dist_sat < sq_best[SQ_STAGES]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sq_valid[SQ_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.hit          <= hit_next;
      res.hit_distance <= hit_next ? dist_sat : sq_best[SQ_STAGES];
      res.hit_x        <= hit_next ? sq_p[SQ_STAGES][0] : '0;
      res.hit_y        <= hit_next ? sq_p[SQ_STAGES][1] : '0;
      res.hit_z        <= hit_next ? sq_p[SQ_STAGES][2] : '0;
    end
  end

  assign res.valid = out_valid;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a miss carries a zero position
  a_miss_zero_pos: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.hit |-> res.hit_x == '0 && res.hit_y == '0 && res.hit_z == '0)
    else $error("miss result with nonzero position");

  // a hit is strictly nearer than some best distance, so never all ones
  a_hit_dist_bound: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.hit |-> res.hit_distance != '1)
    else $error("hit distance at saturation value");

  // input back-pressure only while a result is waiting
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !ray.ready |-> res.valid && !res.ready)
    else $error("ray channel stalled without output stall");

endmodule

// ===== design/rbsi_div_pipe.sv =====
// ============================================================================
// Ray/box slab intersection - pipelined divider
// Restoring unsigned divide of (num << FRAC_BITS) by den, DIV_BITS quotient
// bits per stage, magnitude capped.
// ============================================================================
module rbsi_div_pipe import rbsi_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [NUM_W-1:0]       num_mag,
  input  logic [COORD_WIDTH-1:0] den_mag,
  output logic [QW-1:0]          quot
);

  logic [QW-1:0]          dvd [0:DIV_STAGES];
  logic [QW-1:0]          quo [0:DIV_STAGES];
  logic [COORD_WIDTH-1:0] rem [0:DIV_STAGES];
  logic [COORD_WIDTH-1:0] den [0:DIV_STAGES];

  // stage 0 inputs: dividend is the numerator with the fraction appended
  assign dvd[0] = QW'({num_mag, {FRAC_BITS{1'b0}}});
  assign quo[0] = '0;
  assign rem[0] = '0;
  assign den[0] = den_mag;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [QW-1:0]          dvd_next;
    logic [QW-1:0]          quo_next;
    logic [COORD_WIDTH-1:0] rem_next;

    // DIV_BITS shift/compare/subtract steps
    always_comb begin
      logic [COORD_WIDTH:0] rs;
      logic [QW-1:0]        dv;
      logic [QW-1:0]        q;
      logic [COORD_WIDTH-1:0] r;
      dv = dvd[s];
      q  = quo[s];
      r  = rem[s];
      for (int k = 0; k < DIV_BITS; k++) begin
        rs = {r, dv[QW-1]};
        dv = {dv[QW-2:0], 1'b0};
        if (rs >= {1'b0, den[s]}) begin
          rs = rs - {1'b0, den[s]};
          q  = {q[QW-2:0], 1'b1};
        end else begin
          q  = {q[QW-2:0], 1'b0};
        end
        r = rs[COORD_WIDTH-1:0];
      end
      dvd_next = dv;
      quo_next = q;
      rem_next = r;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvd[s+1] <= dvd_next;
        quo[s+1] <= quo_next;
        rem[s+1] <= rem_next;
        den[s+1] <= den[s];
      end
    end
  end

  // magnitude cap, only reachable for wide formats
  assign quot = (QW > QCAP_BIT && quo[DIV_STAGES] > QCAP) ? QCAP : quo[DIV_STAGES];

endmodule
